@@ src/fjd_pkg.sv @@
// shared types and codes of the feed jam detector
package fjd_pkg;

    // per-channel jam states
    localparam logic [2:0] ST_NORMAL    = 3'd0;
    localparam logic [2:0] ST_SUSPECTED = 3'd1;
    localparam logic [2:0] ST_CONFIRMED = 3'd2;
    localparam logic [2:0] ST_RECOVERY  = 3'd3;
    localparam logic [2:0] ST_FAILED    = 3'd4;

    // request kinds
    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_RECOVERY = 2'd1;
    localparam logic [1:0] REQ_RESET    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_MOVEMENT  = 2'd0;
    localparam logic [1:0] CFG_STALL_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd2;

    localparam int CFG_DATA_W = 20;
    localparam int SDATA_W    = 72;
    localparam int MDATA_W    = 8;

    localparam logic [15:0] MIN_MOVEMENT_RST  = 16'd50;
    localparam logic [19:0] STALL_TIMEOUT_RST = 20'd5000;
    localparam logic [3:0]  MAX_ATTEMPTS_RST  = 4'd3;

    typedef struct packed {
        logic [2:0]  chan_state;
        logic [31:0] prev_position;
        logic [31:0] last_motion;
        logic [31:0] suspect_start;
        logic [3:0]  recovery_count;
    } t_rec;

    typedef struct packed {
        logic [15:0] min_movement;
        logic [19:0] stall_timeout;
        logic [3:0]  max_attempts;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] position;
        logic        feeding;
    } t_req;

endpackage

@@ src/fjd_update.sv @@
// next-record logic for one request on one channel record
module fjd_update (
    input  fjd_pkg::t_cfg i_cfg,
    input  fjd_pkg::t_req i_req,
    input  fjd_pkg::t_rec i_rec,
    output fjd_pkg::t_rec o_rec,
    output logic          o_granted
);
    import fjd_pkg::*;

    logic [32:0] diff;
    logic [32:0] move;
    logic [31:0] since_motion;
    logic [31:0] since_suspect;
    logic        moved;
    logic        stalled;
    logic        suspect_done;

    // exact 33-bit position difference, cannot overflow
    assign diff = {i_req.position[31], i_req.position}
                - {i_rec.prev_position[31], i_rec.prev_position};
    assign move = diff[32] ? (33'd0 - diff) : diff;
    assign moved = move >= {17'd0, i_cfg.min_movement};

    // wrapping time differences
    assign since_motion  = i_req.now_ms - i_rec.last_motion;
    assign since_suspect = i_req.now_ms - i_rec.suspect_start;
    assign stalled       = since_motion >= {12'd0, i_cfg.stall_timeout};
    assign suspect_done  = since_suspect >= {12'd0, i_cfg.stall_timeout};

    always_comb begin
        o_rec     = i_rec;
        o_granted = 1'b0;
        unique case (i_req.req_type)
            REQ_SAMPLE: begin
                if (i_req.feeding) begin
                    if (moved) begin
                        o_rec.last_motion    = i_req.now_ms;
                        o_rec.chan_state     = ST_NORMAL;
                        o_rec.recovery_count = 4'd0;
                    end else if (stalled) begin
                        if (i_rec.chan_state == ST_NORMAL) begin
                            o_rec.chan_state    = ST_SUSPECTED;
                            o_rec.suspect_start = i_req.now_ms;
                        end else if (i_rec.chan_state == ST_SUSPECTED && suspect_done) begin
                            o_rec.chan_state = ST_CONFIRMED;
                        end
                    end
                    o_rec.prev_position = i_req.position;
                end else begin
                    o_rec.last_motion = i_req.now_ms;
                    if (i_rec.chan_state != ST_RECOVERY) begin
                        o_rec.chan_state = ST_NORMAL;
                    end
                end
            end
            REQ_RECOVERY: begin
                if (i_rec.recovery_count >= i_cfg.max_attempts) begin
                    o_rec.chan_state = ST_FAILED;
                end else begin
                    o_granted        = 1'b1;
                    o_rec.chan_state = ST_RECOVERY;
                    if (i_rec.recovery_count != 4'hF) begin
                        o_rec.recovery_count = i_rec.recovery_count + 4'd1;
                    end
                end
            end
            REQ_RESET: begin
                o_rec.chan_state     = ST_NORMAL;
                o_rec.recovery_count = 4'd0;
                o_rec.last_motion    = i_req.now_ms;
            end
            default: begin
                // unused request code leaves the channel as it is
            end
        endcase
    end

endmodule

@@ src/feed_jam_detector_core.sv @@
// top level of the per-channel filament feed jam detector
// Each request is handled in turn: the channel record is read from a registered-read
// memory in the cycle of acceptance, then updated, written back and presented as a result
// once the output register is free to take it. No new request is accepted until that update
// is done. A finished result waits in an output register and does not block the next request.
// After reset every channel reads as normal with all counts and times at zero; the per-channel
// valid bits make this immediate, with no clearing pass. Channels at or beyond CHANNELS give an
// all-zero result and change nothing. Configuration writes are taken in any cycle and should
// only be made while no request is in flight.
module feed_jam_detector_core #(
    parameter int CHANNELS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // channel[1:0], now_ms[33:2], position[65:34], feeding[66], zero fill
    input  logic [fjd_pkg::SDATA_W-1:0]    i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // jam_status[2:0], recovery_granted[3], attempts_used[7:4]
    output logic [fjd_pkg::MDATA_W-1:0]    o_m_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [1:0]                     i_cfg_index,
    input  logic [fjd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fjd_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cfg                r_cfg;
    t_rec                r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    logic                r_busy;
    t_req                r_req;
    logic [CH_W-1:0]     r_idx;
    logic                r_ch_ok;
    t_rec                r_rd_rec;
    logic                r_rd_hit;
    logic                r_out_valid;
    logic [MDATA_W-1:0]  r_out_data;

    logic            in_acc;
    logic            out_free;
    logic            upd_fire;
    logic [1:0]      ch_in;
    logic [CH_W-1:0] rd_idx;
    logic            ch_ok_in;
    t_req            req_in;
    t_rec            cur_rec;
    t_rec            new_rec;
    logic            granted;

    assign ch_in    = i_s_tdata[1:0];
    assign rd_idx   = CH_W'(ch_in);
    assign ch_ok_in = 32'(ch_in) < CHANNELS;

    assign req_in.req_type = i_s_tuser;
    assign req_in.now_ms   = i_s_tdata[33:2];
    assign req_in.position = i_s_tdata[65:34];
    assign req_in.feeding  = i_s_tdata[66];

    assign o_s_tready = !r_busy;
    assign in_acc     = i_s_tvalid && !r_busy;
    assign out_free   = !r_out_valid || i_m_tready;
    assign upd_fire   = r_busy && out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // entries never written read as the reset record
    assign cur_rec = r_rd_hit ? r_rd_rec : '0;

    fjd_update u_update (
        .i_cfg     (r_cfg),
        .i_req     (r_req),
        .i_rec     (cur_rec),
        .o_rec     (new_rec),
        .o_granted (granted)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_movement  <= MIN_MOVEMENT_RST;
            r_cfg.stall_timeout <= STALL_TIMEOUT_RST;
            r_cfg.max_attempts  <= MAX_ATTEMPTS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MIN_MOVEMENT:  r_cfg.min_movement  <= i_cfg_data[15:0];
                CFG_STALL_TIMEOUT: r_cfg.stall_timeout <= i_cfg_data[19:0];
                CFG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // channel record memory, registered read
    always_ff @(posedge i_clk) begin
        if (upd_fire && r_ch_ok) begin
            r_mem[r_idx] <= new_rec;
        end
        if (in_acc) begin
            r_rd_rec <= r_mem[rd_idx];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req    <= req_in;
            r_idx    <= rd_idx;
            r_ch_ok  <= ch_ok_in;
            r_rd_hit <= ch_ok_in && r_valid[rd_idx];
        end
        if (upd_fire) begin
            r_out_data <= r_ch_ok ? {new_rec.recovery_count, granted, new_rec.chan_state}
                                  : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire && r_ch_ok) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (upd_fire) begin
                r_busy <= 1'b0;
            end
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("accepted request did not start an update");

    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> o_m_tvalid)
        else $error("update finished without a result");

    a_grant_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3]) |-> (o_m_tdata[2:0] == ST_RECOVERY))
        else $error("recovery granted but channel not in recovery");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_valid & $past(r_valid)) == $past(r_valid)))
        else $error("channel valid bit dropped outside reset");
`endif

endmodule
